// File: hdl/ppbd_pkg.sv
// ----------------------------------------------------------------------------
// ppbd_pkg
// Shared types and constants for the pending packet buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ppbd_pkg;

    localparam int PPBD_DEPTH = 64;
    localparam int LIMIT_W = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    localparam logic [1:0] MODE_ARRIVE = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    typedef enum logic [2:0] {
        KIND_REQUEST = 3'd0,
        KIND_QUEUED = 3'd1,
        KIND_DROPPED = 3'd2,
        KIND_SENT = 3'd3,
        KIND_NONE = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        OP_DROP_NR,
        OP_ARRIVE,
        OP_RELEASE,
        OP_FLUSH,
        OP_NONE
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ARR_EMIT,
        S_ARR_FIN,
        S_WALK,
        S_WALK_END
    } t_state;

    typedef struct packed {
        logic [1:0] mode;
        logic user_ready;
        logic [31:0] dst_ip;
        logic [31:0] src_ip;
        logic [7:0] protocol;
        logic [15:0] packet_handle;
        logic release_verdict;
    } t_in;

    typedef struct packed {
        logic [2:0] kind;
        logic [15:0] handle_out;
        logic [31:0] src_out;
        logic [31:0] dst_out;
        logic [7:0] protocol_out;
        logic last;
    } t_out;

    typedef struct packed {
        logic [31:0] dst;
        logic [31:0] src;
        logic [7:0] proto;
        logic [15:0] handle;
    } t_slot;

    typedef struct packed {
        t_op op;
        t_in item;
    } t_cmd;

    localparam int SLOT_W = $bits(t_slot);

    function automatic t_out mk_out(t_kind kind, logic [15:0] handle, logic [31:0] src,
                                    logic [31:0] dst, logic [7:0] proto, logic last);
        t_out r;
        r.kind = kind;
        r.handle_out = handle;
        r.src_out = src;
        r.dst_out = dst;
        r.protocol_out = proto;
        r.last = last;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ppbd_ram.sv
// ----------------------------------------------------------------------------
// ppbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppbd_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/ppbd_front.sv
// ----------------------------------------------------------------------------
// ppbd_front
// Accepts commands, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ppbd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  ppbd_pkg::t_in      i_item,
    output logic               o_busy,
    output logic               o_valid,
    output ppbd_pkg::t_cmd     o_head,
    input  wire logic          i_pop
);
    import ppbd_pkg::*;

    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd cmd;
    logic push;

    always_comb begin
        cmd.item = i_item;
        case (i_item.mode)
            MODE_ARRIVE:  cmd.op = t_op'(i_item.user_ready ? OP_ARRIVE : OP_DROP_NR);
            MODE_RELEASE: cmd.op = OP_RELEASE;
            MODE_FLUSH:   cmd.op = OP_FLUSH;
            default:      cmd.op = OP_NONE;
        endcase
    end

    assign o_busy = (r_cnt == 2'd2);
    assign push = i_start && !o_busy;
    assign o_valid = (r_cnt != 2'd0);
    assign o_head = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_busy && !i_pop) |=> o_busy) else $error("full queue lost an item");
`endif

endmodule

`default_nettype wire

// File: hdl/ppbd_back.sv
// ----------------------------------------------------------------------------
// ppbd_back
// Sequencer: scans, compacts and emits results from the slot RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module ppbd_back #(
    parameter int DEPTH = ppbd_pkg::PPBD_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [ppbd_pkg::LIMIT_W-1:0]  i_limit,
    input  wire logic                          i_valid,
    input  ppbd_pkg::t_cmd                     i_head,
    output logic                               o_pop,
    output logic                               o_strobe,
    output ppbd_pkg::t_out                     o_result
);
    import ppbd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);
    localparam int LW = (OW > LIMIT_W) ? OW : LIMIT_W;

    t_state r_state, n_state;
    t_cmd r_cmd, n_cmd;
    logic [OW-1:0] r_occ, n_occ, r_rd, n_rd, r_keep, n_keep;
    logic r_pv, n_pv, r_pend, n_pend, r_hold_v, n_hold_v, r_strobe, n_strobe;
    t_out r_hold, n_hold, r_out, n_out;

    logic ram_we;
    logic [AW-1:0] ram_waddr;
    t_slot ram_wdata, ram_rdata;
    logic issue, match, room;
    logic [LW-1:0] lim_ext, eff;
    t_slot cmd_slot;

    assign lim_ext = LW'(i_limit);
    assign eff = (lim_ext > LW'(DEPTH)) ? LW'(DEPTH) : lim_ext;
    assign room = LW'(r_occ) < eff;
    assign issue = ((r_state == S_SCAN) || (r_state == S_WALK)) && (r_rd < r_occ);
    assign match = (r_cmd.op == OP_FLUSH) || (ram_rdata.dst == r_cmd.item.dst_ip);

    assign cmd_slot.dst = r_cmd.item.dst_ip;
    assign cmd_slot.src = r_cmd.item.src_ip;
    assign cmd_slot.proto = r_cmd.item.protocol;
    assign cmd_slot.handle = r_cmd.item.packet_handle;

    ppbd_ram #(.W(SLOT_W), .D(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_head.op)
                        OP_ARRIVE: n_state = (r_occ == '0) ? S_ARR_EMIT : S_SCAN;
                        OP_RELEASE, OP_FLUSH: n_state = (r_occ == '0) ? S_IDLE : S_WALK;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: if (r_rd == r_occ && !r_pv) n_state = S_ARR_EMIT;
            S_ARR_EMIT: n_state = r_pend ? S_IDLE : S_ARR_FIN;
            S_ARR_FIN: n_state = S_IDLE;
            S_WALK: if (r_rd == r_occ && !r_pv) n_state = S_WALK_END;
            S_WALK_END: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd = r_cmd;
        n_occ = r_occ;
        n_rd = issue ? r_rd + 1'b1 : r_rd;
        n_pv = issue;
        n_keep = r_keep;
        n_pend = r_pend;
        n_hold_v = r_hold_v;
        n_hold = r_hold;
        n_strobe = 1'b0;
        n_out = r_out;
        o_pop = 1'b0;
        ram_we = 1'b0;
        ram_waddr = r_keep[AW-1:0];
        ram_wdata = ram_rdata;
        case (r_state)
            S_IDLE: begin
                n_rd = '0;
                n_keep = '0;
                n_pend = 1'b0;
                n_hold_v = 1'b0;
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_head;
                    case (i_head.op)
                        OP_DROP_NR: begin
                            n_strobe = 1'b1;
                            n_out = mk_out(KIND_DROPPED, i_head.item.packet_handle,
                                i_head.item.src_ip, i_head.item.dst_ip,
                                i_head.item.protocol, 1'b1);
                        end
                        OP_RELEASE, OP_FLUSH: begin
                            if (r_occ == '0) begin
                                n_strobe = 1'b1;
                                n_out = mk_out(KIND_NONE, '0, '0, '0, '0, 1'b1);
                            end
                        end
                        OP_ARRIVE: n_strobe = 1'b0;
                        default: begin
                            n_strobe = 1'b1;
                            n_out = mk_out(KIND_NONE, '0, '0, '0, '0, 1'b1);
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_pv && match) begin
                    n_pend = 1'b1;
                end
            end
            S_ARR_EMIT, S_ARR_FIN: begin
                n_strobe = 1'b1;
                if (r_state == S_ARR_EMIT && !r_pend) begin
                    n_out = mk_out(KIND_REQUEST, cmd_slot.handle, cmd_slot.src,
                        cmd_slot.dst, cmd_slot.proto, 1'b0);
                end else if (room) begin
                    ram_we = 1'b1;
                    ram_waddr = r_occ[AW-1:0];
                    ram_wdata = cmd_slot;
                    n_occ = r_occ + 1'b1;
                    n_out = mk_out(KIND_QUEUED, cmd_slot.handle, cmd_slot.src,
                        cmd_slot.dst, cmd_slot.proto, 1'b1);
                end else begin
                    n_out = mk_out(KIND_DROPPED, cmd_slot.handle, cmd_slot.src,
                        cmd_slot.dst, cmd_slot.proto, 1'b1);
                end
            end
            S_WALK: begin
                if (r_pv) begin
                    if (match) begin
                        // emit the previous hit; the newest one waits to learn 'last'
                        n_strobe = r_hold_v;
                        n_out = r_hold;
                        n_hold_v = 1'b1;
                        n_hold = mk_out(t_kind'((r_cmd.op == OP_RELEASE &&
                            r_cmd.item.release_verdict) ? KIND_SENT : KIND_DROPPED),
                            ram_rdata.handle, ram_rdata.src,
                            ram_rdata.dst, ram_rdata.proto, 1'b0);
                    end else begin
                        ram_we = 1'b1;
                        n_keep = r_keep + 1'b1;
                    end
                end
            end
            S_WALK_END: begin
                n_strobe = 1'b1;
                n_out = r_hold_v ? r_hold : mk_out(KIND_NONE, '0, '0, '0, '0, 1'b0);
                n_out.last = 1'b1;
                n_occ = (r_cmd.op == OP_FLUSH) ? '0 : r_keep;
            end
            default: n_strobe = 1'b0;
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_hold <= n_hold;
        r_out <= n_out;
        r_rd <= n_rd;
        r_keep <= n_keep;
        r_pend <= n_pend;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ <= '0;
            r_pv <= 1'b0;
            r_hold_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ <= n_occ;
            r_pv <= n_pv;
            r_hold_v <= n_hold_v;
            r_strobe <= n_strobe;
        end
    end

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(DEPTH)) else $error("occupancy above depth");
    a_keep_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_keep <= r_rd)) else $error("compaction overran reads");
    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_END && r_cmd.op == OP_FLUSH) |=> (r_occ == '0))
        else $error("flush left entries");
`endif

endmodule

`default_nettype wire

// File: hdl/pending_packet_buffer_by_destination_core.sv
// ----------------------------------------------------------------------------
// pending_packet_buffer_by_destination_core
// Holds packets that wait for a route, released or flushed by destination.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_item and raise start; the item is taken at an
//   edge where start is high and busy is low. A two-entry command queue sits
//   in front of the sequencer, so busy rises only when both entries wait.
//   Results: one per cycle on o_result, marked by o_strobe, last set on the
//   final result of each item. The receiver cannot stall; results are never
//   held back.
//   Config channel: i_cfg_data carries queue_limit; always ready. Write only
//   while no item is in flight.
// Sequencing (N = packets held), from the accepting edge to the last result:
//   not-ready arrival / unknown mode / empty release or flush: a single result.
//   arrival into an empty buffer: route request, then queued (dropped at limit 0).
//   arrival otherwise: destination scan over the N entries, one slot RAM read per
//   cycle; a route request only when no held entry matches, then queued or dropped.
//   release / flush: one RAM read per entry, with matches emitted and survivors
//   compacted in the same pass.
// Reset: clears the queue, sequencer and occupancy; the limit returns to 64.
// Slot RAM contents are not cleared; only entries below occupancy are read.
// ----------------------------------------------------------------------------
`default_nettype none

module pending_packet_buffer_by_destination_core #(
    parameter int DEPTH = ppbd_pkg::PPBD_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  ppbd_pkg::t_in                      i_item,
    output logic                               o_strobe,
    output ppbd_pkg::t_out                     o_result,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ppbd_pkg::LIMIT_W-1:0]  i_cfg_data
);
    import ppbd_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic q_valid, q_pop;
    t_cmd q_head;

    // limit register, written through its own channel
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    // front: decode and queue commands
    ppbd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .o_busy  (busy),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    // back: slot RAM sequencer
    ppbd_back #(.DEPTH(DEPTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_limit  (r_limit),
        .i_valid  (q_valid),
        .i_head   (q_head),
        .o_pop    (q_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
